// ----- rtl/apnm_pkg.sv -----
// Shared types and constants for the amplitude pair noise mixer.
// No dependencies; every other RTL file except apnm_ram imports it.
`default_nettype none
package apnm_pkg;

  localparam int MAX_QUBITS = 10;
  localparam int AMP_WIDTH  = 16;
  localparam int DEPTH      = 1 << MAX_QUBITS;
  localparam int ADDR_W     = MAX_QUBITS;
  localparam int WORD_W     = 2 * AMP_WIDTH;
  localparam int NOISE_W    = 17;
  localparam int QCNT_W     = 4;
  localparam int TGT_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int POW_W      = 2 * AMP_WIDTH;
  localparam int ACC_W      = POW_W + NOISE_W;
  localparam int MAG_W      = AMP_WIDTH + 1;

  localparam logic [NOISE_W-1:0]   NOISE_ONE = NOISE_W'(65536);
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_QCNT  = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    OP_WRITE     = 2'd0,
    OP_APPLY_ONE = 2'd1,
    OP_APPLY_ALL = 2'd2,
    OP_READ      = 2'd3
  } apnm_op_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RDWAIT, ST_RDA, ST_RDB, ST_CAPB, ST_MULA, ST_MULB,
    ST_SQINIT, ST_SQRT, ST_WR, ST_RESP
  } apnm_state_e;

  typedef enum logic [2:0] {
    RAM_NONE, RAM_HOST_WR, RAM_HOST_RD, RAM_RD_I, RAM_RD_J, RAM_WR_RES
  } apnm_ram_e;

  typedef enum logic [1:0] {
    OUT_ZERO, OUT_READ, OUT_ERR
  } apnm_out_e;

  typedef struct packed {
    apnm_ram_e ram;
    logic      tgt_load;
    logic      tgt_zero;
    logic      tgt_inc;
    logic      pair_clr;
    logic      pair_inc;
    logic      sel_clr;
    logic      sel_set;
    logic      cap_a;
    logic      cap_b;
    logic      cap_rd;
    logic      mul_a;
    logic      mul_b;
    logic      sq_init;
    logic      sq_step;
    logic      out_load;
    apnm_out_e out_kind;
  } apnm_cmd_t;

  typedef struct packed {
    apnm_op_e op;
    logic     tgt_bad;
    logic     all_skip;
    logic     sel;
    logic     pair_last;
    logic     tgt_last;
    logic     sq_last;
    logic     out_free;
  } apnm_stat_t;

endpackage
`default_nettype wire

// ----- rtl/apnm_if.sv -----
// Channel interfaces: item input, result output, register write.
// Depends on apnm_pkg.
`default_nettype none
interface apnm_in_if;
  import apnm_pkg::*;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  operation;
  logic [ADDR_W-1:0]           amp_index;
  logic signed [AMP_WIDTH-1:0] real_in;
  logic signed [AMP_WIDTH-1:0] imag_in;
  logic [TGT_W-1:0]            target_qubit;
  modport source (output valid, operation, amp_index, real_in, imag_in, target_qubit,
                  input ready);
  modport sink (input valid, operation, amp_index, real_in, imag_in, target_qubit,
                output ready);
endinterface

interface apnm_out_if;
  import apnm_pkg::*;
  logic                        valid;
  logic                        ready;
  logic signed [AMP_WIDTH-1:0] real_out;
  logic signed [AMP_WIDTH-1:0] imag_out;
  logic                        status;
  modport source (output valid, real_out, imag_out, status, input ready);
  modport sink (input valid, real_out, imag_out, status, output ready);
endinterface

interface apnm_cfg_if;
  import apnm_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [NOISE_W-1:0]   data;
  modport source (output valid, reg_index, data, input ready);
  modport sink (input valid, reg_index, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/apnm_ram.sv -----
// Generic single-port RAM, write-enable, registered read.
// No dependencies.
`default_nettype none
module apnm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule
`default_nettype wire

// ----- rtl/apnm_ctrl.sv -----
// Sequencer for the mixer: item intake, pair walk, result hand-off.
// Depends on apnm_pkg; drives apnm_dp through command and status structs.
`default_nettype none
module apnm_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire apnm_pkg::apnm_stat_t st_i,
  output apnm_pkg::apnm_cmd_t       cmd_o
);
  import apnm_pkg::*;

  apnm_state_e state_q, state_d;
  apnm_out_e   kind_q, kind_d;
  logic        all_q, all_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      kind_q  <= OUT_ZERO;
      all_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
      all_q   <= all_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d      = state_q;
    kind_d       = kind_q;
    all_d        = all_q;
    in_ready_o   = 1'b0;
    cmd_o        = '0;
    cmd_o.ram    = RAM_NONE;
    cmd_o.out_kind = kind_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (st_i.op)
            OP_WRITE: begin
              cmd_o.ram = RAM_HOST_WR;
              kind_d    = OUT_ZERO;
              state_d   = ST_RESP;
            end
            OP_READ: begin
              cmd_o.ram = RAM_HOST_RD;
              kind_d    = OUT_READ;
              state_d   = ST_RDWAIT;
            end
            OP_APPLY_ONE: begin
              if (st_i.tgt_bad) begin
                kind_d  = OUT_ERR;
                state_d = ST_RESP;
              end else begin
                cmd_o.tgt_load = 1'b1;
                cmd_o.pair_clr = 1'b1;
                kind_d  = OUT_ZERO;
                all_d   = 1'b0;
                state_d = ST_RDA;
              end
            end
            OP_APPLY_ALL: begin
              kind_d = OUT_ZERO;
              if (st_i.all_skip) begin
                state_d = ST_RESP;
              end else begin
                cmd_o.tgt_zero = 1'b1;
                cmd_o.pair_clr = 1'b1;
                all_d   = 1'b1;
                state_d = ST_RDA;
              end
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_RDWAIT: begin
        cmd_o.cap_rd = 1'b1;
        state_d = ST_RESP;
      end
      ST_RDA: begin
        cmd_o.ram = RAM_RD_I;
        state_d = ST_RDB;
      end
      ST_RDB: begin
        cmd_o.ram   = RAM_RD_J;
        cmd_o.cap_a = 1'b1;
        state_d = ST_CAPB;
      end
      ST_CAPB: begin
        cmd_o.cap_b   = 1'b1;
        cmd_o.sel_clr = 1'b1;
        state_d = ST_MULA;
      end
      ST_MULA: begin
        cmd_o.mul_a = 1'b1;
        state_d = ST_MULB;
      end
      ST_MULB: begin
        cmd_o.mul_b = 1'b1;
        state_d = ST_SQINIT;
      end
      ST_SQINIT: begin
        cmd_o.sq_init = 1'b1;
        state_d = ST_SQRT;
      end
      ST_SQRT: begin
        cmd_o.sq_step = 1'b1;
        if (st_i.sq_last) state_d = ST_WR;
      end
      ST_WR: begin
        cmd_o.ram = RAM_WR_RES;
        priority if (!st_i.sel) begin
          cmd_o.sel_set = 1'b1;
          state_d = ST_MULA;
        end else if (!st_i.pair_last) begin
          cmd_o.pair_inc = 1'b1;
          state_d = ST_RDA;
        end else if (all_q && !st_i.tgt_last) begin
          cmd_o.tgt_inc  = 1'b1;
          cmd_o.pair_clr = 1'b1;
          state_d = ST_RDA;
        end else begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (st_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ----- rtl/apnm_dp.sv -----
// Datapath: registers, amplitude RAM, power, mix multiply, square root, result.
// Depends on apnm_pkg and apnm_ram.
`default_nettype none
module apnm_dp (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire apnm_pkg::apnm_cmd_t                   cmd_i,
  output apnm_pkg::apnm_stat_t                       st_o,
  input  wire logic [1:0]                            operation_i,
  input  wire logic [apnm_pkg::ADDR_W-1:0]           amp_index_i,
  input  wire logic signed [apnm_pkg::AMP_WIDTH-1:0] real_in_i,
  input  wire logic signed [apnm_pkg::AMP_WIDTH-1:0] imag_in_i,
  input  wire logic [apnm_pkg::TGT_W-1:0]            target_qubit_i,
  input  wire logic                                  cfg_valid_i,
  input  wire logic [apnm_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  wire logic [apnm_pkg::NOISE_W-1:0]          cfg_data_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output logic signed [apnm_pkg::AMP_WIDTH-1:0]      real_out_o,
  output logic signed [apnm_pkg::AMP_WIDTH-1:0]      imag_out_o,
  output logic                                       status_o
);
  import apnm_pkg::*;

  // configuration registers
  logic [NOISE_W-1:0] noise_q;
  logic [QCNT_W-1:0]  qcnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      noise_q <= '0;
      qcnt_q  <= QCNT_W'(MAX_QUBITS);
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_NOISE) noise_q <= cfg_data_i;
      if (cfg_index_i == CFG_QCNT)  qcnt_q  <= cfg_data_i[QCNT_W-1:0];
    end
  end

  logic [QCNT_W-1:0]  n_eff;
  logic [NOISE_W-1:0] noise_eff;
  logic [NOISE_W:0]   keep, xfer;

  assign n_eff     = (qcnt_q > QCNT_W'(MAX_QUBITS)) ? QCNT_W'(MAX_QUBITS) : qcnt_q;
  assign noise_eff = (noise_q > NOISE_ONE) ? NOISE_ONE : noise_q;
  assign xfer      = {1'b0, noise_eff};
  assign keep      = {1'b1, {NOISE_W{1'b0}}} - xfer;

  // walk registers: target, pair counter, half select
  logic [TGT_W-1:0]  tgt_q;
  logic [ADDR_W-1:0] k_q;
  logic              sel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_q <= '0;
      k_q   <= '0;
      sel_q <= 1'b0;
    end else begin
      if (cmd_i.tgt_load)     tgt_q <= target_qubit_i;
      else if (cmd_i.tgt_zero) tgt_q <= '0;
      else if (cmd_i.tgt_inc)  tgt_q <= tgt_q + TGT_W'(1);
      if (cmd_i.pair_clr)      k_q <= '0;
      else if (cmd_i.pair_inc) k_q <= k_q + ADDR_W'(1);
      if (cmd_i.sel_clr)       sel_q <= 1'b0;
      else if (cmd_i.sel_set)  sel_q <= 1'b1;
    end
  end

  // pair addresses: insert a zero at the target's bit position
  logic [TGT_W-1:0]  pos;
  logic [ADDR_W-1:0] m, i_addr, j_addr, half;

  assign pos    = TGT_W'(n_eff) - TGT_W'(1) - tgt_q;
  assign m      = ADDR_W'(1) << pos;
  assign i_addr = ((k_q >> pos) << (pos + TGT_W'(1))) | (k_q & (m - ADDR_W'(1)));
  assign j_addr = i_addr | m;
  assign half   = ADDR_W'(1) << (n_eff - QCNT_W'(1));

  // amplitude memory, {imag, real}
  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;
  logic [AMP_WIDTH-1:0] res_real;

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = '0;
    ram_wdata = '0;
    unique case (cmd_i.ram)
      RAM_NONE: ram_addr = '0;
      RAM_HOST_WR: begin
        ram_we    = 1'b1;
        ram_addr  = amp_index_i;
        ram_wdata = {imag_in_i, real_in_i};
      end
      RAM_HOST_RD: ram_addr = amp_index_i;
      RAM_RD_I:    ram_addr = i_addr;
      RAM_RD_J:    ram_addr = j_addr;
      RAM_WR_RES: begin
        ram_we    = 1'b1;
        ram_addr  = sel_q ? j_addr : i_addr;
        ram_wdata = {{AMP_WIDTH{1'b0}}, res_real};
      end
      default: ram_addr = '0;
    endcase
  end

  apnm_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // power of the word just read
  logic signed [AMP_WIDTH-1:0] rd_re, rd_im;
  logic signed [POW_W-1:0]     sq_re, sq_im;
  logic [POW_W-1:0]            pw;

  assign rd_re = ram_rdata[AMP_WIDTH-1:0];
  assign rd_im = ram_rdata[WORD_W-1:AMP_WIDTH];
  assign sq_re = rd_re * rd_re;
  assign sq_im = rd_im * rd_im;
  assign pw    = $unsigned(sq_re) + $unsigned(sq_im);

  logic [POW_W-1:0]  p0_q, p1_q;
  logic              neg_a_q, neg_b_q;
  logic [WORD_W-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_a) begin
      p0_q    <= pw;
      neg_a_q <= ram_rdata[AMP_WIDTH-1];
    end
    if (cmd_i.cap_b) begin
      p1_q    <= pw;
      neg_b_q <= ram_rdata[AMP_WIDTH-1];
    end
    if (cmd_i.cap_rd) rd_q <= ram_rdata;
  end

  // mix: one shared multiplier, used in turn for both terms of each new probability
  logic [NOISE_W:0]      ka, kb, kmul;
  logic [POW_W-1:0]      pmul;
  logic [ACC_W+NOISE_W:0] prod;
  logic [ACC_W-1:0]      acc_q;

  assign ka   = sel_q ? xfer : keep;
  assign kb   = sel_q ? keep : xfer;
  assign kmul = cmd_i.mul_b ? kb : ka;
  assign pmul = cmd_i.mul_b ? p1_q : p0_q;
  assign prod = kmul * pmul;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_a)      acc_q <= prod[ACC_W-1:0];
    else if (cmd_i.mul_b) acc_q <= acc_q + prod[ACC_W-1:0];
  end

  // integer square root, one result bit per cycle
  logic [ACC_W-1:0] acc_rnd;
  logic [POW_W-1:0] rem_q, root_q, bit_q;
  logic [POW_W:0]   trial;

  assign acc_rnd = acc_q + ACC_W'(1 << (NOISE_W - 1));
  assign trial   = {1'b0, root_q} + {1'b0, bit_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_init) begin
      rem_q  <= acc_rnd[ACC_W-1:NOISE_W];
      root_q <= '0;
      bit_q  <= POW_W'(1) << (POW_W - 2);
    end else if (cmd_i.sq_step) begin
      if ({1'b0, rem_q} >= trial) begin
        rem_q  <= rem_q - trial[POW_W-1:0];
        root_q <= (root_q >> 1) + bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  // round, restore sign of the old real part, saturate
  logic [MAG_W-1:0] mag;
  logic [MAG_W-1:0] neg_mag;
  logic             old_neg;

  assign mag     = root_q[MAG_W-1:0] + MAG_W'(rem_q > root_q);
  assign neg_mag = MAG_W'(0) - mag;
  assign old_neg = sel_q ? neg_b_q : neg_a_q;

  always_comb begin
    if (old_neg) begin
      res_real = (mag > (MAG_W'(1) << (AMP_WIDTH - 1))) ?
                 {1'b1, {(AMP_WIDTH-1){1'b0}}} : neg_mag[AMP_WIDTH-1:0];
    end else begin
      res_real = (mag > {2'b00, {(AMP_WIDTH-1){1'b1}}}) ?
                 {1'b0, {(AMP_WIDTH-1){1'b1}}} : mag[AMP_WIDTH-1:0];
    end
  end

  // result register
  logic                 out_valid_q;
  logic [AMP_WIDTH-1:0] out_re_q, out_im_q;
  logic                 out_st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      unique case (cmd_i.out_kind)
        OUT_READ: begin
          out_re_q <= rd_q[AMP_WIDTH-1:0];
          out_im_q <= rd_q[WORD_W-1:AMP_WIDTH];
          out_st_q <= 1'b0;
        end
        OUT_ERR: begin
          out_re_q <= '0;
          out_im_q <= '0;
          out_st_q <= 1'b1;
        end
        default: begin
          out_re_q <= '0;
          out_im_q <= '0;
          out_st_q <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign real_out_o  = out_re_q;
  assign imag_out_o  = out_im_q;
  assign status_o    = out_st_q;

  // status toward the sequencer
  assign st_o.op        = apnm_op_e'(operation_i);
  assign st_o.tgt_bad   = {1'b0, target_qubit_i} >= {1'b0, n_eff};
  assign st_o.all_skip  = (noise_eff == '0) || (n_eff == '0);
  assign st_o.sel       = sel_q;
  assign st_o.pair_last = k_q == (half - ADDR_W'(1));
  assign st_o.tgt_last  = tgt_q == (TGT_W'(n_eff) - TGT_W'(1));
  assign st_o.sq_last   = bit_q == POW_W'(1);
  assign st_o.out_free  = !out_valid_q || out_ready_i;
endmodule
`default_nettype wire

// ----- rtl/amplitude_pair_noise_mixer.sv -----
// Top level of the amplitude pair noise mixer: sequencer plus datapath.
// Depends on apnm_pkg, apnm_if, apnm_ctrl, apnm_dp.
//
// channel  dir  beat contents
// in_b     in   operation, amp_index, real_in, imag_in, target_qubit
// out_b    out  real_out, imag_out, status
// cfg_b    in   reg_index (0 noise_level, 1 qubit_count), data
//
// Write and read end in the response state; a read first waits on the registered RAM read.
// Apply to one target (error status if target >= n) walks 2^(n-1) pairs; each pair is two RAM reads,
// then per half two multiply steps, one round step, 16 root steps, one write.
// Apply to all: n times the pair walk, skipped when noise or n is zero. One item at a time; a result waits in
// the output register and the next item is taken meanwhile.
// Reset restores control and config (no noise, ten qubits); RAM contents are undefined until written.
`default_nettype none
module amplitude_pair_noise_mixer (
  input wire logic clk_i,
  input wire logic rst_ni,
  apnm_in_if.sink  in_b,
  apnm_out_if.source out_b,
  apnm_cfg_if.sink cfg_b
);
  import apnm_pkg::*;

  apnm_cmd_t  cmd;
  apnm_stat_t st;

  assign cfg_b.ready = 1'b1;

  apnm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_b.valid),
    .in_ready_o (in_b.ready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  apnm_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .st_o           (st),
    .operation_i    (in_b.operation),
    .amp_index_i    (in_b.amp_index),
    .real_in_i      (in_b.real_in),
    .imag_in_i      (in_b.imag_in),
    .target_qubit_i (in_b.target_qubit),
    .cfg_valid_i    (cfg_b.valid),
    .cfg_index_i    (cfg_b.reg_index),
    .cfg_data_i     (cfg_b.data),
    .out_valid_o    (out_b.valid),
    .out_ready_i    (out_b.ready),
    .real_out_o     (out_b.real_out),
    .imag_out_o     (out_b.imag_out),
    .status_o       (out_b.status)
  );
endmodule
`default_nettype wire

// ----- test/amplitude_pair_noise_mixer_tb.sv -----
// Self-checking testbench for amplitude_pair_noise_mixer: directed table with fixed expectations
// plus random items, each checked against a bit-accurate model of the noise step.
// Depends on apnm_pkg, apnm_if and the RTL top level.
`timescale 1ns / 100ps
module amplitude_pair_noise_mixer_tb;
  import apnm_pkg::*;

  localparam int WDOG_LIMIT = 200000;

  typedef struct packed {
    logic [1:0]         op;
    logic [ADDR_W-1:0]  idx;
    logic signed [15:0] re;
    logic signed [15:0] im;
    logic [TGT_W-1:0]   tgt;
  } amp_item_t;

  typedef struct packed {
    logic signed [15:0] re;
    logic signed [15:0] im;
    logic               st;
  } amp_res_t;

  typedef struct packed {
    amp_item_t it;
    amp_res_t  res;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  apnm_in_if  in_b ();
  apnm_out_if out_b ();
  apnm_cfg_if cfg_b ();

  amplitude_pair_noise_mixer u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_b  (in_b),
    .out_b (out_b),
    .cfg_b (cfg_b)
  );

  // model state
  logic signed [15:0] vec_re [DEPTH];
  logic signed [15:0] vec_im [DEPTH];
  bit                 written [DEPTH];
  logic [NOISE_W-1:0] noise_cfg;
  logic [QCNT_W-1:0]  qcnt_cfg;

  amp_res_t pending_q[$];
  int       err_cnt;
  int       send_idle;
  int       recv_stall;
  int       hold_req;

  // clock and reset
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // ---------------- predictor ----------------
  function automatic longint unsigned amp_power(int k);
    longint r;
    longint i;
    r = vec_re[k];
    i = vec_im[k];
    return longint'(r * r + i * i);
  endfunction

  function automatic longint unsigned root_nearest(longint unsigned x);
    longint unsigned rem;
    longint unsigned root;
    longint unsigned b;
    rem  = x;
    root = 0;
    b    = 64'd1 << 62;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= root + b) begin
        rem  = rem - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    if (rem > root) root = root + 1;
    return root;
  endfunction

  // (ka*pa + kb*pb + 2^16) >> 17 without overflow
  function automatic longint unsigned blend_power(longint unsigned ka, longint unsigned pa,
                                                  longint unsigned kb, longint unsigned pb);
    longint unsigned hi;
    longint unsigned lo;
    hi = ka * (pa >> 17) + kb * (pb >> 17);
    lo = ka * (pa & 64'h1FFFF) + kb * (pb & 64'h1FFFF);
    return hi + ((lo + 64'h10000) >> 17);
  endfunction

  function automatic void settle_amp(int k, longint unsigned pr);
    longint unsigned mag;
    longint          v;
    mag = root_nearest(pr);
    if (vec_re[k] < 0) v = (mag > 32768) ? -32768 : -longint'(mag);
    else v = (mag > 32767) ? 32767 : longint'(mag);
    vec_re[k] = v[15:0];
    vec_im[k] = '0;
  endfunction

  function automatic void mix_target(int n, int t, longint unsigned nz);
    int              dim;
    int              m;
    longint unsigned keep;
    longint unsigned p0;
    longint unsigned p1;
    longint unsigned a;
    longint unsigned b;
    dim  = 1 << n;
    m    = 1 << (n - 1 - t);
    keep = 131072 - nz;
    for (int lo = 0; lo < dim; lo += 2 * m) begin
      for (int i = lo; i < lo + m; i++) begin
        p0 = amp_power(i);
        p1 = amp_power(i | m);
        a  = blend_power(keep, p0, nz, p1);
        b  = blend_power(nz, p0, keep, p1);
        settle_amp(i, a);
        settle_amp(i | m, b);
      end
    end
  endfunction

  function automatic int eff_qubits();
    return (qcnt_cfg > MAX_QUBITS) ? MAX_QUBITS : int'(qcnt_cfg);
  endfunction

  function automatic amp_res_t predict_amp(amp_item_t it);
    amp_res_t        r;
    int              n;
    longint unsigned nz;
    r  = '0;
    n  = eff_qubits();
    nz = (noise_cfg > NOISE_ONE) ? 65536 : longint'(noise_cfg);
    case (apnm_op_e'(it.op))
      OP_WRITE: begin
        vec_re[it.idx]  = it.re;
        vec_im[it.idx]  = it.im;
        written[it.idx] = 1'b1;
      end
      OP_APPLY_ONE: begin
        if (int'(it.tgt) >= n) r.st = 1'b1;
        else mix_target(n, it.tgt, nz);
      end
      OP_APPLY_ALL: begin
        if (nz > 0) for (int t = 0; t < n; t++) mix_target(n, t, nz);
      end
      default: begin
        r.re = vec_re[it.idx];
        r.im = vec_im[it.idx];
      end
    endcase
    return r;
  endfunction

  // ---------------- drivers ----------------
  task automatic send_item(amp_item_t it, bit typed, amp_res_t want);
    amp_res_t r;
    if ($urandom_range(99) < send_idle) begin
      in_b.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle);
    end
    in_b.valid        <= 1'b1;
    in_b.operation    <= it.op;
    in_b.amp_index    <= it.idx;
    in_b.real_in      <= it.re;
    in_b.imag_in      <= it.im;
    in_b.target_qubit <= it.tgt;
    do @(posedge clk_i); while (!in_b.ready);
    r = predict_amp(it);
    pending_q.push_back(typed ? want : r);
  endtask

  task automatic drain_results();
    while (pending_q.size() != 0) @(posedge clk_i);
  endtask

  // registers change only with the block idle
  task automatic write_reg(logic [CFG_IDX_W-1:0] ri, logic [NOISE_W-1:0] val);
    in_b.valid <= 1'b0;
    drain_results();
    repeat (5) @(posedge clk_i);
    cfg_b.valid     <= 1'b1;
    cfg_b.reg_index <= ri;
    cfg_b.data      <= val;
    do @(posedge clk_i); while (!cfg_b.ready);
    cfg_b.valid <= 1'b0;
    if (ri == CFG_NOISE) noise_cfg = val;
    else if (ri == CFG_QCNT) qcnt_cfg = val[QCNT_W-1:0];
  endtask

  function automatic logic signed [15:0] pick_value();
    case ($urandom_range(7))
      0: begin
        case ($urandom_range(3))
          0: return 16'sh7FFF;
          1: return 16'sh8000;
          2: return 16'sh0000;
          default: return 16'shFFFF;
        endcase
      end
      1: return 16'($signed($urandom_range(511)) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic amp_item_t random_item(int n);
    amp_item_t it;
    int        dim;
    int        sel;
    dim    = 1 << n;
    it.op  = OP_WRITE;
    it.idx = 10'($urandom);
    it.re  = 16'($urandom);
    it.im  = 16'($urandom);
    it.tgt = 4'($urandom);
    sel    = $urandom_range(99);
    if (sel < 40) begin
      it.op  = OP_WRITE;
      it.idx = ($urandom_range(3) == 0) ? 10'($urandom_range(1023)) : 10'($urandom_range(dim - 1));
      it.re  = pick_value();
      it.im  = pick_value();
    end else if (sel < 75) begin
      it.op = OP_READ;
      if ($urandom_range(1) == 0) it.idx = 10'($urandom_range(dim - 1));
      else do it.idx = 10'($urandom_range(1023)); while (!written[it.idx]);
    end else if (sel < 90) begin
      it.op = OP_APPLY_ONE;
      if (n > 0 && $urandom_range(3) != 0) it.tgt = 4'($urandom_range(n - 1));
    end else begin
      it.op = OP_APPLY_ALL;
    end
    return it;
  endfunction

  // fill the active vector so apply steps never touch unwritten entries
  task automatic fill_vector(int dim);
    amp_item_t it;
    for (int k = 0; k < dim; k++) begin
      it = '{op: OP_WRITE, idx: 10'(k), re: pick_value(), im: pick_value(), tgt: 4'($urandom)};
      send_item(it, 1'b0, '0);
    end
  endtask

  // ---------------- receiver and checker ----------------
  initial begin
    int       hold_left;
    amp_res_t want;
    hold_left   = 0;
    out_b.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_b.valid && out_b.ready) begin
        if (pending_q.size() == 0) begin
          $error("unexpected result beat re=%0d im=%0d st=%0d",
                 out_b.real_out, out_b.imag_out, out_b.status);
          err_cnt++;
        end else begin
          want = pending_q.pop_front();
          if (out_b.real_out !== want.re) begin
            $error("real_out expected %0d actual %0d", want.re, out_b.real_out);
            err_cnt++;
          end
          if (out_b.imag_out !== want.im) begin
            $error("imag_out expected %0d actual %0d", want.im, out_b.imag_out);
            err_cnt++;
          end
          if (out_b.status !== want.st) begin
            $error("status expected %0d actual %0d", want.st, out_b.status);
            err_cnt++;
          end
        end
      end
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_b.ready <= 1'b0;
      end else begin
        out_b.ready <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  // watchdog: cycles without any beat
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni || (in_b.valid && in_b.ready) || (out_b.valid && out_b.ready) ||
          (cfg_b.valid && cfg_b.ready)) quiet = 0;
      else quiet++;
      if (quiet >= WDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // ---------------- stimulus ----------------
  initial begin
    dir_row_t  dir_tab [11];
    amp_item_t it;
    int        ph_noise [8];
    int        ph_qcnt  [8];
    int        ph_items [8];
    int        n;

    err_cnt    = 0;
    send_idle  = 0;
    recv_stall = 0;
    hold_req   = 0;
    noise_cfg  = '0;
    qcnt_cfg   = 4'd10;
    foreach (written[k]) begin
      written[k] = 1'b0;
      vec_re[k]  = '0;
      vec_im[k]  = '0;
    end
    in_b.valid        <= 1'b0;
    in_b.operation    <= OP_WRITE;
    in_b.amp_index    <= '0;
    in_b.real_in      <= '0;
    in_b.imag_in      <= '0;
    in_b.target_qubit <= '0;
    cfg_b.valid       <= 1'b0;
    cfg_b.reg_index   <= CFG_NOISE;
    cfg_b.data        <= '0;

    // reset config: ten qubits, no noise; results read straight off
    dir_tab = '{
      '{'{OP_WRITE,     10'd0,    16'sh7FFF, 16'sh8000, 4'd0},  '{16'sh0000, 16'sh0000, 1'b0}},
      '{'{OP_READ,      10'd0,    16'sh0000, 16'sh0000, 4'd0},  '{16'sh7FFF, 16'sh8000, 1'b0}},
      '{'{OP_WRITE,     10'd1023, 16'sh8000, 16'sh7FFF, 4'd15}, '{16'sh0000, 16'sh0000, 1'b0}},
      '{'{OP_READ,      10'd1023, 16'sh1234, 16'sh5678, 4'd9},  '{16'sh8000, 16'sh7FFF, 1'b0}},
      '{'{OP_WRITE,     10'd512,  16'sh0000, 16'shFFFF, 4'd0},  '{16'sh0000, 16'sh0000, 1'b0}},
      '{'{OP_READ,      10'd512,  16'sh0000, 16'sh0000, 4'd0},  '{16'sh0000, 16'shFFFF, 1'b0}},
      '{'{OP_APPLY_ONE, 10'd0,    16'sh0000, 16'sh0000, 4'd10}, '{16'sh0000, 16'sh0000, 1'b1}},
      '{'{OP_APPLY_ONE, 10'd511,  16'shFFFF, 16'shFFFF, 4'd15}, '{16'sh0000, 16'sh0000, 1'b1}},
      '{'{OP_APPLY_ALL, 10'd0,    16'sh0000, 16'sh0000, 4'd0},  '{16'sh0000, 16'sh0000, 1'b0}},
      '{'{OP_READ,      10'd0,    16'sh0000, 16'sh0000, 4'd0},  '{16'sh7FFF, 16'sh8000, 1'b0}},
      '{'{OP_READ,      10'd1023, 16'sh0000, 16'sh0000, 4'd0},  '{16'sh8000, 16'sh7FFF, 1'b0}}
    };

    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    foreach (dir_tab[k]) send_item(dir_tab[k].it, 1'b1, dir_tab[k].res);

    // full vector: count above the maximum clamps to ten, noise above one saturates
    write_reg(CFG_NOISE, 17'h1FFFF);
    write_reg(CFG_QCNT, 17'd15);
    write_reg(2'd2, 17'($urandom));
    fill_vector(DEPTH);
    it = '{op: OP_APPLY_ONE, idx: '0, re: '0, im: '0, tgt: 4'd0};
    send_item(it, 1'b0, '0);
    it.tgt = 4'd9;
    send_item(it, 1'b0, '0);
    write_reg(CFG_NOISE, NOISE_ONE);
    write_reg(CFG_QCNT, 17'd10);
    it.tgt = 4'd4;
    send_item(it, 1'b0, '0);
    for (int k = 0; k < 8; k++) begin
      it = '{op: OP_READ, idx: 10'($urandom), re: '0, im: '0, tgt: '0};
      send_item(it, 1'b0, '0);
    end

    // random phases, mostly small vectors
    ph_noise = '{0, 65536, 1, -1, 40000, -1, 32768, -1};
    ph_qcnt  = '{1, 2, 3, 4, 0, 3, 2, 4};
    ph_items = '{50, 60, 60, 70, 30, 70, 60, 50};
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_NOISE, (ph_noise[ph] < 0) ? 17'($urandom_range(65536)) : 17'(ph_noise[ph]));
      write_reg(CFG_QCNT, 17'(ph_qcnt[ph]));
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 57; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 57; end
        default: begin send_idle = 16; recv_stall = 16; end
      endcase
      n = eff_qubits();
      fill_vector(1 << n);
      for (int k = 0; k < ph_items[ph]; k++) begin
        if (ph == 3 && k == ph_items[ph] / 2) hold_req = 400;
        if (ph == 5 && k == ph_items[ph] / 2) begin
          in_b.valid <= 1'b0;
          drain_results();
        end
        send_item(random_item(n), 1'b0, '0);
      end
    end

    in_b.valid <= 1'b0;
    drain_results();
    repeat (50) @(posedge clk_i);
    if (err_cnt == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
